>>> src/mhtq_pkg.sv
// Shared types and constants for the min-heap timer queue.
// Holds the heap entry layout, result codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package mhtq_pkg;

   localparam int HEAP_DEPTH  = 16;
   localparam int MAX_RESULTS = 16;

   localparam int IDX_W  = $clog2(HEAP_DEPTH);
   localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
   localparam int CH_W   = IDX_W + 2;
   localparam int N_W    = $clog2(MAX_RESULTS + 1);

   localparam int DL_W   = 32;
   localparam int TIN_W  = 16;
   localparam int TMO_W  = 15;
   localparam int TL_W   = 5;
   localparam int KIND_W = 3;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;

   typedef enum logic {
      REQ_ARM  = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      RK_ARMED       = 3'd0,
      RK_BAD_TIMEOUT = 3'd1,
      RK_FULL        = 3'd2,
      RK_FIRED       = 3'd3,
      RK_NONE        = 3'd4
   } result_kind_type;

   typedef struct packed {
      logic [DL_W-1:0]  deadline;
      logic [TMO_W-1:0] tmo;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_UP_CHECK,
      ST_UP_CMP,
      ST_POP_RD,
      ST_POP_CHK,
      ST_DN_LAST,
      ST_DN_CHECK,
      ST_DN_C1,
      ST_DN_C2,
      ST_DN_CMP,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic            load_req;
      logic            set_kind;
      result_kind_type kind;
      logic            arm_start;
      logic            tick_start;
      logic            rd_parent;
      logic            up_move;
      logic            place_mv;
      logic            rd_root;
      logic            pop;
      logic            rd_last;
      logic            take_last;
      logic            rd_c1;
      logic            take_c1;
      logic            rd_c2;
      logic            take_c2;
      logic            dn_move;
      logic            emit_end;
   } dp_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic bad_tmo;
      logic full;
      logic pos_zero;
      logic up_stop;
      logic cnt_zero;
      logic cnt_one;
      logic n_max;
      logic root_due;
      logic pend_v;
      logic out_free;
      logic c1_out;
      logic c2_out;
      logic c2_less;
      logic dn_stop;
   } dp_status_type;

endpackage

`default_nettype wire

>>> src/mhtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the heap entry store. No dependencies.
`default_nettype none

module mhtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> src/mhtq_ctrl.sv
// Controller state machine for the timer queue: sequences sift-up,
// pop and sift-down steps and result emission. Depends on mhtq_pkg.
`default_nettype none

module mhtq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire mhtq_pkg::dp_status_type status,
   output mhtq_pkg::dp_cmd_type        cmd
);

   import mhtq_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.kind   = RK_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.set_kind = 1'b1;
            priority if (status.is_tick) begin
               cmd.kind       = RK_NONE;
               cmd.tick_start = 1'b1;
               state_in       = ST_POP_RD;
            end else if (status.bad_tmo) begin
               cmd.kind = RK_BAD_TIMEOUT;
               state_in = ST_FINISH;
            end else if (status.full) begin
               cmd.kind = RK_FULL;
               state_in = ST_FINISH;
            end else begin
               cmd.kind      = RK_ARMED;
               cmd.arm_start = 1'b1;
               state_in      = ST_UP_CHECK;
            end
         end
         ST_UP_CHECK: begin
            if (status.pos_zero) begin
               cmd.place_mv = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            // stop below a parent with an equal or earlier deadline
            if (status.up_stop) begin
               cmd.place_mv = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               cmd.up_move = 1'b1;
               state_in    = ST_UP_CHECK;
            end
         end
         ST_POP_RD: begin
            if (status.cnt_zero || status.n_max) begin
               state_in = ST_FINISH;
            end else begin
               cmd.rd_root = 1'b1;
               state_in    = ST_POP_CHK;
            end
         end
         ST_POP_CHK: begin
            if (!status.root_due) begin
               state_in = ST_FINISH;
            end else if (!status.pend_v || status.out_free) begin
               cmd.pop = 1'b1;
               if (status.cnt_one) begin
                  state_in = ST_POP_RD;
               end else begin
                  cmd.rd_last = 1'b1;
                  state_in    = ST_DN_LAST;
               end
            end
         end
         ST_DN_LAST: begin
            cmd.take_last = 1'b1;
            state_in      = ST_DN_CHECK;
         end
         ST_DN_CHECK: begin
            if (status.c1_out) begin
               cmd.place_mv = 1'b1;
               state_in     = ST_POP_RD;
            end else begin
               cmd.rd_c1 = 1'b1;
               state_in  = ST_DN_C1;
            end
         end
         ST_DN_C1: begin
            cmd.take_c1 = 1'b1;
            if (status.c2_out) begin
               state_in = ST_DN_CMP;
            end else begin
               cmd.rd_c2 = 1'b1;
               state_in  = ST_DN_C2;
            end
         end
         ST_DN_C2: begin
            cmd.take_c2 = status.c2_less;
            state_in    = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (status.dn_stop) begin
               cmd.place_mv = 1'b1;
               state_in     = ST_POP_RD;
            end else begin
               cmd.dn_move = 1'b1;
               state_in    = ST_DN_CHECK;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit_end = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/mhtq_dp.sv
// Datapath of the timer queue: request registers, heap RAM ports, sift
// registers, pending fired result and the result output register.
// Depends on mhtq_pkg and mhtq_ram.
`default_nettype none

module mhtq_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [mhtq_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic [0:0]                          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [mhtq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                     rsp_tlast,
   input  wire mhtq_pkg::dp_cmd_type                cmd,
   output mhtq_pkg::dp_status_type                  status
);

   import mhtq_pkg::*;

   // request fields
   req_kind_type            type_ff,  type_in;
   logic [DL_W-1:0]         now_ff,   now_in;
   logic signed [TIN_W-1:0] tin_ff,   tin_in;

   // heap control
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [N_W-1:0]          n_ff,     n_in;
   logic [IDX_W-1:0]        pos_ff,   pos_in;
   logic [IDX_W-1:0]        chpos_ff, chpos_in;
   entry_type               mv_ff,    mv_in;
   entry_type               ch_ff,    ch_in;
   result_kind_type         kind_ff,  kind_in;

   // fired result held back until its last flag is known
   logic                    pend_v_ff,    pend_v_in;
   entry_type               pend_ff,      pend_in;
   logic [CNT_W-1:0]        pend_left_ff, pend_left_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   result_kind_type         rsp_kind_ff,  rsp_kind_in;
   logic [DL_W-1:0]         rsp_dl_ff,    rsp_dl_in;
   logic [TMO_W-1:0]        rsp_tmo_ff,   rsp_tmo_in;
   logic [TL_W-1:0]         rsp_left_ff,  rsp_left_in;
   logic                    rsp_last_ff,  rsp_last_in;

   // RAM ports
   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   entry_type               ram_wdata;
   logic                    ram_re;
   logic [IDX_W-1:0]        ram_raddr;
   entry_type               ram_rdata;
   logic [ENTRY_W-1:0]      ram_rdata_raw;

   logic [IDX_W-1:0]        parent;
   logic [CH_W-1:0]         c1;
   logic [CH_W-1:0]         c2;
   logic [CH_W-1:0]         count_ext;
   logic [DL_W:0]           dl_sum;
   logic [DL_W-1:0]         dl_sat;
   logic                    out_free;

   mhtq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HEAP_DEPTH)
   ) u_heap_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata_raw)
   );

   assign ram_rdata = entry_type'(ram_rdata_raw);

   assign parent    = (pos_ff - IDX_W'(1)) >> 1;
   assign c1        = {1'b0, pos_ff, 1'b1};
   assign c2        = c1 + CH_W'(1);
   assign count_ext = CH_W'(count_ff);
   assign dl_sum    = {1'b0, now_ff} + (DL_W + 1)'(tin_ff[TMO_W-1:0]);
   assign dl_sat    = dl_sum[DL_W] ? '1 : dl_sum[DL_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      status.is_tick  = (type_ff == REQ_TICK);
      status.bad_tmo  = (tin_ff <= 0);
      status.full     = (count_ff == CNT_W'(HEAP_DEPTH));
      status.pos_zero = (pos_ff == '0);
      status.up_stop  = (ram_rdata.deadline <= mv_ff.deadline);
      status.cnt_zero = (count_ff == '0);
      status.cnt_one  = (count_ff == CNT_W'(1));
      status.n_max    = (n_ff == N_W'(MAX_RESULTS));
      status.root_due = (ram_rdata.deadline <= now_ff);
      status.pend_v   = pend_v_ff;
      status.out_free = out_free;
      status.c1_out   = (c1 >= count_ext);
      status.c2_out   = (c2 >= count_ext);
      status.c2_less  = (ram_rdata.deadline < ch_ff.deadline);
      status.dn_stop  = !(ch_ff.deadline < mv_ff.deadline);
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = pos_ff;
      ram_wdata = mv_ff;
      if (cmd.place_mv) begin
         ram_we = 1'b1;
      end else if (cmd.up_move) begin
         ram_we    = 1'b1;
         ram_wdata = ram_rdata;
      end else if (cmd.dn_move) begin
         ram_we    = 1'b1;
         ram_wdata = ch_ff;
      end

      ram_re    = cmd.rd_parent || cmd.rd_root || cmd.rd_last || cmd.rd_c1 || cmd.rd_c2;
      ram_raddr = '0;
      priority if (cmd.rd_parent) begin
         ram_raddr = parent;
      end else if (cmd.rd_last) begin
         ram_raddr = IDX_W'(count_ff - CNT_W'(1));
      end else if (cmd.rd_c1) begin
         ram_raddr = c1[IDX_W-1:0];
      end else if (cmd.rd_c2) begin
         ram_raddr = c2[IDX_W-1:0];
      end else begin
         ram_raddr = '0;
      end
   end

   always_comb begin
      type_in      = type_ff;
      now_in       = now_ff;
      tin_in       = tin_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      pos_in       = pos_ff;
      chpos_in     = chpos_ff;
      mv_in        = mv_ff;
      ch_in        = ch_ff;
      kind_in      = kind_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      pend_left_in = pend_left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_dl_in    = rsp_dl_ff;
      rsp_tmo_in   = rsp_tmo_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.load_req) begin
         type_in   = req_kind_type'(req_tuser[0]);
         now_in    = req_tdata[DL_W-1:0];
         tin_in    = req_tdata[DL_W +: TIN_W];
         pend_v_in = 1'b0;
      end
      if (cmd.set_kind) begin
         kind_in = cmd.kind;
      end
      if (cmd.arm_start) begin
         mv_in.deadline = dl_sat;
         mv_in.tmo      = tin_ff[TMO_W-1:0];
         pos_in         = IDX_W'(count_ff);
         count_in       = count_ff + CNT_W'(1);
      end
      if (cmd.tick_start) begin
         n_in = '0;
      end
      if (cmd.up_move) begin
         pos_in = parent;
      end
      if (cmd.pop) begin
         // hand the previous fired timer out, it is not the last one
         if (pend_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = RK_FIRED;
            rsp_dl_in    = pend_ff.deadline;
            rsp_tmo_in   = pend_ff.tmo;
            rsp_left_in  = TL_W'(pend_left_ff);
            rsp_last_in  = 1'b0;
         end
         pend_v_in    = 1'b1;
         pend_in      = ram_rdata;
         pend_left_in = count_ff - CNT_W'(1);
         count_in     = count_ff - CNT_W'(1);
         n_in         = n_ff + N_W'(1);
      end
      if (cmd.take_last) begin
         mv_in  = ram_rdata;
         pos_in = '0;
      end
      if (cmd.take_c1) begin
         ch_in    = ram_rdata;
         chpos_in = c1[IDX_W-1:0];
      end
      if (cmd.take_c2) begin
         ch_in    = ram_rdata;
         chpos_in = c2[IDX_W-1:0];
      end
      if (cmd.dn_move) begin
         pos_in = chpos_ff;
      end
      if (cmd.emit_end) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         if (pend_v_ff) begin
            rsp_kind_in = RK_FIRED;
            rsp_dl_in   = pend_ff.deadline;
            rsp_tmo_in  = pend_ff.tmo;
            rsp_left_in = TL_W'(pend_left_ff);
            pend_v_in   = 1'b0;
         end else begin
            rsp_kind_in = kind_ff;
            rsp_dl_in   = '0;
            rsp_tmo_in  = '0;
            rsp_left_in = TL_W'(count_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         n_ff         <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         n_ff         <= n_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff      <= type_in;
      now_ff       <= now_in;
      tin_ff       <= tin_in;
      pos_ff       <= pos_in;
      chpos_ff     <= chpos_in;
      mv_ff        <= mv_in;
      ch_ff        <= ch_in;
      kind_ff      <= kind_in;
      pend_ff      <= pend_in;
      pend_left_ff <= pend_left_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_dl_ff    <= rsp_dl_in;
      rsp_tmo_ff   <= rsp_tmo_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_left_ff, rsp_tmo_ff, rsp_dl_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

>>> src/min_heap_timer_queue.sv
// Binary min-heap timer queue, one request at a time. The heap RAM has one registered read
// port: a sift-up level reads the parent, then compares; a sift-down level reads the first
// child and, if it exists, the second child, then compares. An arm climbs at most 4 levels.
// A waiting result stalls only pops and the finish.
// Reset is synchronous, active high; it empties the heap with no clearing pass.
`default_nettype none

module min_heap_timer_queue (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // now_time [31:0], timeout_secs [47:32]
   input  wire logic [mhtq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type [0]
   input  wire logic [0:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // result_kind [2:0], fired_deadline [34:3], fired_timeout [49:35],
   // timers_left [54:50], zero [55]
   output logic      [mhtq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                                  rsp_tlast
);

   import mhtq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mhtq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mhtq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire
